// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers used by the top-level design file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, ignored while reset is high.
`define BQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define BQ_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: design/bqpp_pkg.sv
// ----------------------------------------------------------------------------
// bqpp_pkg
// Shared types, constants and helpers of the bit queue push/pop unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bqpp_pkg;

   localparam int CAPACITY_BITS_DEFAULT     = 4096;
   localparam int MAX_BITS_PER_ITEM_DEFAULT = 64;

   localparam int WORD_BITS = 64;
   localparam int OFFSET_W  = 6;
   localparam int COUNT_W   = 7;

   typedef enum logic {
      CMD_PUSH = 1'b0,
      CMD_POP  = 1'b1
   } command_type;

   // Per-request control handed from the address stage to the output stage.
   typedef struct packed {
      logic                valid;
      logic [COUNT_W-1:0]  given;
      logic                accepted;
      logic [OFFSET_W-1:0] offset;
      logic                swap;
   } s1_meta_type;

   // Mask of the low n bits, n from 0 to 64.
   function automatic logic [WORD_BITS-1:0] low_mask(input logic [COUNT_W-1:0] n);
      logic [WORD_BITS-1:0] m;
      if (n[COUNT_W-1]) begin
         m = '1;
      end else begin
         m = (WORD_BITS'(1) << n[OFFSET_W-1:0]) - WORD_BITS'(1);
      end
      return m;
   endfunction

endpackage

// File: design/bqpp_bank.sv
// ----------------------------------------------------------------------------
// bqpp_bank
// One bank of word storage with a bit-masked write and a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bqpp_bank #(
   parameter int DEPTH  = 32,
   parameter int ADDR_W = 5
) (
   input  logic                            clock,
   input  logic [ADDR_W-1:0]               addr,
   input  logic                            wr_en,
   input  logic [bqpp_pkg::WORD_BITS-1:0]  wr_data,
   input  logic [bqpp_pkg::WORD_BITS-1:0]  wr_mask,
   input  logic                            rd_en,
   output logic [bqpp_pkg::WORD_BITS-1:0]  rd_data
);
   import bqpp_pkg::*;

   logic [WORD_BITS-1:0] mem [DEPTH];
   logic [WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= (mem[addr] & ~wr_mask) | (wr_data & wr_mask);
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/bqpp_front.sv
// ----------------------------------------------------------------------------
// bqpp_front
// Request register, queue pointers and fill level, bank address and
// write-lane generation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bqpp_front #(
   parameter int CAPACITY_BITS     = bqpp_pkg::CAPACITY_BITS_DEFAULT,
   parameter int MAX_BITS_PER_ITEM = bqpp_pkg::MAX_BITS_PER_ITEM_DEFAULT,
   parameter int BANK_AW           = 5
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_command,
   input  logic [bqpp_pkg::COUNT_W-1:0]    req_bit_count,
   input  logic [bqpp_pkg::WORD_BITS-1:0]  req_push_data,
   input  logic                            take,
   output bqpp_pkg::s1_meta_type           meta,
   output logic [BANK_AW-1:0]              bank0_addr,
   output logic [BANK_AW-1:0]              bank1_addr,
   output logic                            wr_en,
   output logic                            rd_en,
   output logic [bqpp_pkg::WORD_BITS-1:0]  bank0_wr_data,
   output logic [bqpp_pkg::WORD_BITS-1:0]  bank1_wr_data,
   output logic [bqpp_pkg::WORD_BITS-1:0]  bank0_wr_mask,
   output logic [bqpp_pkg::WORD_BITS-1:0]  bank1_wr_mask
);
   import bqpp_pkg::*;

   localparam int POS_W     = $clog2(CAPACITY_BITS);
   localparam int FILL_W    = $clog2(CAPACITY_BITS + 1);
   localparam int NUM_WORDS = CAPACITY_BITS / WORD_BITS;
   localparam int WIDX_W    = POS_W - OFFSET_W;

   logic                 s0_valid_ff;
   command_type          s0_command_ff;
   logic [COUNT_W-1:0]   s0_count_ff;
   logic [WORD_BITS-1:0] s0_data_ff;

   logic [POS_W-1:0]     wr_pos_ff, rd_pos_ff, pos_in;
   logic [FILL_W-1:0]    fill_ff, fill_in;
   s1_meta_type          meta_ff, meta_in;

   logic                 s1_free, s0_move, is_pop, push_ok;
   logic [COUNT_W-1:0]   count_sat, pop_given, step;
   logic [FILL_W-1:0]    free_bits;
   logic [POS_W-1:0]     pos;
   logic [POS_W:0]       pos_sum;
   logic [WIDX_W-1:0]    word, next_word, bank0_word, bank1_word;
   logic [OFFSET_W-1:0]  offset;
   logic [2*WORD_BITS-1:0] span_data, span_mask;

   // Pipeline handshake: the request register drains when the next stage frees.
   assign s1_free   = !meta_ff.valid || take;
   assign s0_move   = s0_valid_ff && s1_free;
   assign req_stall = s0_valid_ff && !s1_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         s0_valid_ff <= 1'b1;
      end else if (s0_move) begin
         s0_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s0_command_ff <= command_type'(req_command);
         s0_count_ff   <= req_bit_count;
         s0_data_ff    <= req_push_data;
      end
   end

   // Saturate the count, then check room or shortage.
   always_comb begin
      is_pop    = (s0_command_ff == CMD_POP);
      count_sat = (s0_count_ff > COUNT_W'(MAX_BITS_PER_ITEM)) ?
                  COUNT_W'(MAX_BITS_PER_ITEM) : s0_count_ff;
      free_bits = FILL_W'(CAPACITY_BITS) - fill_ff;
      push_ok   = (FILL_W'(count_sat) <= free_bits);
      pop_given = (FILL_W'(count_sat) < fill_ff) ? count_sat : COUNT_W'(fill_ff);
      if (is_pop) begin
         step    = pop_given;
         fill_in = fill_ff - FILL_W'(pop_given);
      end else begin
         step    = push_ok ? count_sat : '0;
         fill_in = fill_ff + FILL_W'(step);
      end
   end

   // Ring pointer advance and the two-word span that the request touches.
   always_comb begin
      pos     = is_pop ? rd_pos_ff : wr_pos_ff;
      pos_sum = {1'b0, pos} + (POS_W+1)'(step);
      if (pos_sum >= (POS_W+1)'(CAPACITY_BITS)) begin
         pos_in = POS_W'(pos_sum - (POS_W+1)'(CAPACITY_BITS));
      end else begin
         pos_in = POS_W'(pos_sum);
      end
      word       = pos[POS_W-1:OFFSET_W];
      offset     = pos[OFFSET_W-1:0];
      next_word  = (word == WIDX_W'(NUM_WORDS - 1)) ? '0 : word + WIDX_W'(1);
      bank0_word = word[0] ? next_word : word;
      bank1_word = word[0] ? word : next_word;
      span_data  = {{WORD_BITS{1'b0}}, s0_data_ff} << offset;
      span_mask  = {{WORD_BITS{1'b0}}, low_mask(count_sat)} << offset;
   end

   assign bank0_addr    = BANK_AW'(bank0_word >> 1);
   assign bank1_addr    = BANK_AW'(bank1_word >> 1);
   assign bank0_wr_data = word[0] ? span_data[2*WORD_BITS-1:WORD_BITS] : span_data[WORD_BITS-1:0];
   assign bank1_wr_data = word[0] ? span_data[WORD_BITS-1:0] : span_data[2*WORD_BITS-1:WORD_BITS];
   assign bank0_wr_mask = word[0] ? span_mask[2*WORD_BITS-1:WORD_BITS] : span_mask[WORD_BITS-1:0];
   assign bank1_wr_mask = word[0] ? span_mask[WORD_BITS-1:0] : span_mask[2*WORD_BITS-1:WORD_BITS];
   assign wr_en         = s0_move && !is_pop && push_ok;
   assign rd_en         = s0_move && is_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_pos_ff <= '0;
         rd_pos_ff <= '0;
         fill_ff   <= '0;
      end else if (s0_move) begin
         fill_ff <= fill_in;
         if (is_pop) begin
            rd_pos_ff <= pos_in;
         end else begin
            wr_pos_ff <= pos_in;
         end
      end
   end

   always_comb begin
      meta_in.valid    = 1'b1;
      meta_in.given    = is_pop ? pop_given : '0;
      meta_in.accepted = is_pop ? 1'b1 : push_ok;
      meta_in.offset   = offset;
      meta_in.swap     = word[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         meta_ff.valid <= 1'b0;
      end else if (s0_move) begin
         meta_ff <= meta_in;
      end else if (take) begin
         meta_ff.valid <= 1'b0;
      end
   end

   assign meta = meta_ff;

endmodule

// File: design/bqpp_out.sv
// ----------------------------------------------------------------------------
// bqpp_out
// Aligns the two fetched words into the popped field and holds the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bqpp_out (
   input  logic                            clock,
   input  logic                            reset,
   input  bqpp_pkg::s1_meta_type           meta,
   input  logic [bqpp_pkg::WORD_BITS-1:0]  bank0_rd_data,
   input  logic [bqpp_pkg::WORD_BITS-1:0]  bank1_rd_data,
   output logic                            take,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [bqpp_pkg::WORD_BITS-1:0]  rsp_pop_data,
   output logic [bqpp_pkg::COUNT_W-1:0]    rsp_bits_given,
   output logic                            rsp_accepted
);
   import bqpp_pkg::*;

   logic                   rsp_valid_ff;
   logic [WORD_BITS-1:0]   pop_data_ff, pop_data_in;
   logic [COUNT_W-1:0]     bits_given_ff;
   logic                   accepted_ff;
   logic [2*WORD_BITS-1:0] span;
   logic [WORD_BITS-1:0]   lo_word, hi_word;

   assign take = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      lo_word     = meta.swap ? bank1_rd_data : bank0_rd_data;
      hi_word     = meta.swap ? bank0_rd_data : bank1_rd_data;
      span        = {hi_word, lo_word} >> meta.offset;
      pop_data_in = span[WORD_BITS-1:0] & low_mask(meta.given);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= meta.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take && meta.valid) begin
         pop_data_ff   <= pop_data_in;
         bits_given_ff <= meta.given;
         accepted_ff   <= meta.accepted;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pop_data   = pop_data_ff;
   assign rsp_bits_given = bits_given_ff;
   assign rsp_accepted   = accepted_ff;

endmodule

// File: design/bit_queue_push_pop_unit.sv
// ----------------------------------------------------------------------------
// bit_queue_push_pop_unit
// Bit-granular FIFO: push appends up to 64 bits, pop removes up to 64 bits.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   command, bit_count, push_data
//   rsp      out        rsp_valid/rsp_stall   pop_data, bits_given, accepted
//
// One request per cycle sustained while no held result stalls the pipeline; the
// pointer and fill update of the request register feeds the next request.
// An accepted request passes from the request register through the bank stage
// into the result register.
// Reset (synchronous) clears pointers, fill level and valids; no clearing pass.
// A held result stalls back through the bank stage into the request register.
// CAPACITY_BITS must be a multiple of 128 (two banks of 64-bit words).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bit_queue_push_pop_unit #(
   parameter int CAPACITY_BITS     = bqpp_pkg::CAPACITY_BITS_DEFAULT,
   parameter int MAX_BITS_PER_ITEM = bqpp_pkg::MAX_BITS_PER_ITEM_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_command,
   input  logic [bqpp_pkg::COUNT_W-1:0]    req_bit_count,
   input  logic [bqpp_pkg::WORD_BITS-1:0]  req_push_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [bqpp_pkg::WORD_BITS-1:0]  rsp_pop_data,
   output logic [bqpp_pkg::COUNT_W-1:0]    rsp_bits_given,
   output logic                            rsp_accepted
);
   import bqpp_pkg::*;

   // Words alternate between two banks so any 64-bit span hits each once.
   localparam int NUM_WORDS  = CAPACITY_BITS / WORD_BITS;
   localparam int BANK_DEPTH = NUM_WORDS / 2;
   localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

   s1_meta_type            meta;
   logic                   take;
   logic [BANK_AW-1:0]     bank0_addr, bank1_addr;
   logic                   wr_en, rd_en;
   logic [WORD_BITS-1:0]   bank0_wr_data, bank1_wr_data;
   logic [WORD_BITS-1:0]   bank0_wr_mask, bank1_wr_mask;
   logic [WORD_BITS-1:0]   bank0_rd_data, bank1_rd_data;

   // Request register, pointers, fill level and bank lane generation.
   bqpp_front #(
      .CAPACITY_BITS     (CAPACITY_BITS),
      .MAX_BITS_PER_ITEM (MAX_BITS_PER_ITEM),
      .BANK_AW           (BANK_AW)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_command   (req_command),
      .req_bit_count (req_bit_count),
      .req_push_data (req_push_data),
      .take          (take),
      .meta          (meta),
      .bank0_addr    (bank0_addr),
      .bank1_addr    (bank1_addr),
      .wr_en         (wr_en),
      .rd_en         (rd_en),
      .bank0_wr_data (bank0_wr_data),
      .bank1_wr_data (bank1_wr_data),
      .bank0_wr_mask (bank0_wr_mask),
      .bank1_wr_mask (bank1_wr_mask)
   );

   // Even words.
   bqpp_bank #(
      .DEPTH  (BANK_DEPTH),
      .ADDR_W (BANK_AW)
   ) u_bank0 (
      .clock   (clock),
      .addr    (bank0_addr),
      .wr_en   (wr_en),
      .wr_data (bank0_wr_data),
      .wr_mask (bank0_wr_mask),
      .rd_en   (rd_en),
      .rd_data (bank0_rd_data)
   );

   // Odd words.
   bqpp_bank #(
      .DEPTH  (BANK_DEPTH),
      .ADDR_W (BANK_AW)
   ) u_bank1 (
      .clock   (clock),
      .addr    (bank1_addr),
      .wr_en   (wr_en),
      .wr_data (bank1_wr_data),
      .wr_mask (bank1_wr_mask),
      .rd_en   (rd_en),
      .rd_data (bank1_rd_data)
   );

   // Align fetched words and hold the result for the consumer.
   bqpp_out u_out (
      .clock          (clock),
      .reset          (reset),
      .meta           (meta),
      .bank0_rd_data  (bank0_rd_data),
      .bank1_rd_data  (bank1_rd_data),
      .take           (take),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pop_data   (rsp_pop_data),
      .rsp_bits_given (rsp_bits_given),
      .rsp_accepted   (rsp_accepted)
   );

   // A pop never hands out more than one item's worth of bits.
   `BQ_ASSERT(a_given_bound, clock, reset, rsp_valid |-> (rsp_bits_given <= COUNT_W'(MAX_BITS_PER_ITEM)), "bits_given above item limit")
   // Bits above the given count are zero.
   `BQ_ASSERT(a_data_clean, clock, reset, rsp_valid |-> ((rsp_pop_data & ~low_mask(rsp_bits_given)) == '0), "pop_data has bits above bits_given")
   // A rejected push carries no bits.
   `BQ_ASSERT(a_reject_empty, clock, reset, (rsp_valid && !rsp_accepted) |-> (rsp_bits_given == '0), "rejected push reports bits")
   // A bank-stage entry blocked by a held result stays put.
   `BQ_ASSERT(a_meta_hold, clock, reset, (meta.valid && !take) |=> (meta.valid && $stable(meta)), "bank stage lost a blocked request")

endmodule
